>>> hw/rtl/v3n_pkg.sv
package v3n_pkg;
   localparam int CompW  = 24;
   localparam int MagW   = 24;
   localparam int SumW   = 50;
   localparam int RootW  = 25;
   localparam int OutW   = 32;
   localparam int QuoW   = 31;
   localparam int SqrtSteps = 25;
   localparam int DivSteps  = 31;
   localparam logic [OutW-1:0] OneQ30 = 32'h4000_0000;
   localparam logic OpNormalize = 1'b0;
   localparam logic OpPerp      = 1'b1;

   typedef struct packed {
      logic                perp;
      logic [2:0]          neg;
      logic [2:0][MagW:0]  mag;
   } vec_type;
endpackage

>>> hw/rtl/v3n_sqrt_pipe.sv
module v3n_sqrt_pipe import v3n_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [SumW-1:0]         in_sum,
   input  vec_type                 in_vec,
   output logic                    out_valid,
   output logic [RootW-1:0]        out_root,
   output vec_type                 out_vec
);
   logic [SqrtSteps:0]                   valid_ff;
   logic [SqrtSteps:0][SumW-1:0]         rem_ff;
   logic [SqrtSteps:0][SumW-1:0]         rad_ff;
   logic [SqrtSteps:0][RootW-1:0]        root_ff;
   vec_type [SqrtSteps:0]                vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SqrtSteps-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      rad_ff[0]  <= in_sum;
      root_ff[0] <= '0;
      vec_ff[0]  <= in_vec;
   end

   // one result bit per stage: restoring digit recurrence
   for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
      logic [SumW+1:0] rem_sh;
      logic [SumW+1:0] trial;
      always_comb begin
         rem_sh = {rem_ff[s], rad_ff[s][SumW-1:SumW-2]};
         trial  = {{(SumW+2-RootW-2){1'b0}}, root_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         rad_ff[s+1] <= {rad_ff[s][SumW-3:0], 2'b00};
         vec_ff[s+1] <= vec_ff[s];
         if (rem_sh >= trial) begin
            rem_ff[s+1]  <= SumW'(rem_sh - trial);
            root_ff[s+1] <= {root_ff[s][RootW-2:0], 1'b1};
         end else begin
            rem_ff[s+1]  <= SumW'(rem_sh);
            root_ff[s+1] <= {root_ff[s][RootW-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[SqrtSteps];
   assign out_root  = root_ff[SqrtSteps];
   assign out_vec   = vec_ff[SqrtSteps];
endmodule

>>> hw/rtl/v3n_div_pipe.sv
module v3n_div_pipe import v3n_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [MagW:0]         in_mag,
   input  logic [RootW-1:0]      in_len,
   output logic                  out_valid,
   output logic [QuoW-1:0]       out_quo
);
   // mag <= len always, so quotient of mag<<30 fits 31 bits
   localparam int RemW = RootW + 1;
   logic [DivSteps:0]                valid_ff;
   logic [DivSteps:0][RemW-1:0]      rem_ff;
   logic [DivSteps:0][QuoW-1:0]      quo_ff;
   logic [DivSteps:0][RootW-1:0]     len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DivSteps-1:0], in_valid};
      end
   end

   // dividend is mag<<30: the part above the low 31 bits is mag>>1, already below len
   always_ff @(posedge clock) begin
      rem_ff[0] <= RemW'(in_mag[MagW:1]);
      quo_ff[0] <= {in_mag[0], {(QuoW-1){1'b0}}};
      len_ff[0] <= in_len;
   end

   for (genvar s = 0; s < DivSteps; s++) begin : g_step
      logic [RemW:0] rem_sh;
      assign rem_sh = {rem_ff[s], quo_ff[s][QuoW-1]};
      always_ff @(posedge clock) begin
         len_ff[s+1] <= len_ff[s];
         if (rem_sh >= {2'b00, len_ff[s]}) begin
            rem_ff[s+1] <= RemW'(rem_sh - {2'b00, len_ff[s]});
            quo_ff[s+1] <= {quo_ff[s][QuoW-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= RemW'(rem_sh);
            quo_ff[s+1] <= {quo_ff[s][QuoW-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[DivSteps];
   assign out_quo   = quo_ff[DivSteps];
endmodule

>>> hw/rtl/vec3_normalize_unit.sv
// Vector normalizer, signed Q8.16 in, signed Q1.30 out.
// Request: drive req_operation (0 normalize, 1 perpendicular via cross
// with +z) and req_in_x/y/z with start high; the item is taken on any
// edge where busy is low. busy is always low here: a new item may enter
// every cycle, one item per cycle sustained.
// Response: rsp_strobe marks one cycle holding rsp_out_x/y/z and
// rsp_degenerate. The receiver cannot stall; results arrive in order.
// Pipeline: squares, sum, square root (one bit per stage), degenerate
// check, divide (one bit per stage), then sign and select, each
// registered in that order between accept and strobe; the root and
// divide pipelines are bit-serial.
// Degenerate: length below min_length gives (0,0,0) for normalize and
// (1,0,0) for perpendicular, with rsp_degenerate set.
// Config: csr_valid/csr_ready write min_length; csr_ready is always high.
// Write it only while no item is in flight.
// Reset: synchronous, clears all valid bits and sets min_length to 1.
module vec3_normalize_unit import v3n_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_operation,
   input  logic signed [CompW-1:0] req_in_x,
   input  logic signed [CompW-1:0] req_in_y,
   input  logic signed [CompW-1:0] req_in_z,
   output logic                   rsp_strobe,
   output logic signed [OutW-1:0] rsp_out_x,
   output logic signed [OutW-1:0] rsp_out_y,
   output logic signed [OutW-1:0] rsp_out_z,
   output logic                   rsp_degenerate,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CompW-1:0]       csr_min_length
);
   localparam int SqW = 2*(MagW+1);
   logic [CompW-1:0] min_len_ff;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= CompW'(1);
      end else if (csr_valid) begin
         min_len_ff <= csr_min_length;
      end
   end

   // stage 1: swap for perpendicular, take magnitudes, square
   vec_type vec_in;
   logic signed [CompW:0] c0, c1, c2;
   always_comb begin
      if (req_operation == OpPerp) begin
         c0 = CompW'(0) + (CompW+1)'(req_in_y);
         c1 = -(CompW+1)'(req_in_x);
         c2 = '0;
      end else begin
         c0 = (CompW+1)'(req_in_x);
         c1 = (CompW+1)'(req_in_y);
         c2 = (CompW+1)'(req_in_z);
      end
      vec_in.perp   = req_operation;
      vec_in.neg    = {c2[CompW], c1[CompW], c0[CompW]};
      vec_in.mag[0] = c0[CompW] ? (MagW+1)'(-c0) : (MagW+1)'(c0);
      vec_in.mag[1] = c1[CompW] ? (MagW+1)'(-c1) : (MagW+1)'(c1);
      vec_in.mag[2] = c2[CompW] ? (MagW+1)'(-c2) : (MagW+1)'(c2);
   end

   logic             v1_ff;
   vec_type          vec1_ff;
   logic [2:0][SqW-1:0] sq_ff;
   logic             v2_ff;
   vec_type          vec2_ff;
   logic [SumW-1:0]  sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      vec1_ff <= vec_in;
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= SqW'(vec_in.mag[i]) * SqW'(vec_in.mag[i]);
      end
      // stage 2: sum of squares, at most 3*2^46
      vec2_ff <= vec1_ff;
      sum_ff  <= SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]);
   end

   logic             sq_valid;
   logic [RootW-1:0] root;
   vec_type          vec3;

   v3n_sqrt_pipe u_sqrt (
      .clock, .reset,
      .in_valid (v2_ff), .in_sum (sum_ff), .in_vec (vec2_ff),
      .out_valid (sq_valid), .out_root (root), .out_vec (vec3)
   );

   // check degenerate; substitute len 1 to keep the divider defined
   logic             v4_ff;
   vec_type          vec4_ff;
   logic [RootW-1:0] len4_ff;
   logic             deg4_ff;
   logic             zero4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      vec4_ff  <= vec3;
      deg4_ff  <= root < RootW'(min_len_ff);
      zero4_ff <= root == '0;
      len4_ff  <= (root == '0) ? RootW'(1) : root;
   end

   logic [2:0]           dv;
   logic [2:0][QuoW-1:0] quo;
   for (genvar i = 0; i < 3; i++) begin : g_div
      v3n_div_pipe u_div (
         .clock, .reset,
         .in_valid (v4_ff), .in_mag (vec4_ff.mag[i]), .in_len (len4_ff),
         .out_valid (dv[i]), .out_quo (quo[i])
      );
   end

   // carry side info alongside the divide pipes
   localparam int SideW = 5;
   logic [DivSteps:0][SideW-1:0] side_ff;
   always_ff @(posedge clock) begin
      side_ff[0] <= {vec4_ff.perp, deg4_ff, zero4_ff, vec4_ff.neg[1:0]};
      for (int s = 0; s < DivSteps; s++) begin
         side_ff[s+1] <= side_ff[s];
      end
   end
   logic [2:0] neg_z_ff [DivSteps+1];
   always_ff @(posedge clock) begin
      neg_z_ff[0] <= {2'b00, vec4_ff.neg[2]};
      for (int s = 0; s < DivSteps; s++) begin
         neg_z_ff[s+1] <= neg_z_ff[s];
      end
   end

   logic perp_d, deg_d, zero_d;
   logic [2:0] neg_d;
   assign {perp_d, deg_d, zero_d, neg_d[1:0]} = side_ff[DivSteps];
   assign neg_d[2] = neg_z_ff[DivSteps][0];

   // final stage: clamp, apply sign, select fallback
   logic [2:0][OutW-1:0] res;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [OutW-1:0] q;
         q = (OutW'(quo[i]) > OneQ30) ? OneQ30 : OutW'(quo[i]);
         if (deg_d || zero_d) begin
            res[i] = '0;
         end else begin
            res[i] = neg_d[i] ? -q : q;
         end
      end
      if (deg_d && perp_d) begin
         res[0] = OneQ30;
      end
   end

   logic rsp_strobe_ff, rsp_deg_ff;
   logic [2:0][OutW-1:0] rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv[0];
      end
   end
   always_ff @(posedge clock) begin
      rsp_ff     <= res;
      rsp_deg_ff <= deg_d;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_x      = rsp_ff[0];
   assign rsp_out_y      = rsp_ff[1];
   assign rsp_out_z      = rsp_ff[2];
   assign rsp_degenerate = rsp_deg_ff;
   logic unused_dv;
   assign unused_dv = dv[1] ^ dv[2] ^ |neg_z_ff[DivSteps][2:1];
endmodule

>>> hw/rtl/v3n_checker.sv
module v3n_checker import v3n_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input logic signed [OutW-1:0] rsp_out_x,
   input logic signed [OutW-1:0] rsp_out_y,
   input logic signed [OutW-1:0] rsp_out_z,
   input logic                   rsp_degenerate
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_x <= $signed(OneQ30) && rsp_out_x >= -$signed(OneQ30)))
      else $error("x out of range");
   a_deg_yz: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |-> rsp_out_y == 0 && rsp_out_z == 0)
      else $error("degenerate result not zero");
   a_no_spont: assert property (@(posedge clock) disable iff (reset)
      $past(reset, 62) == 1'b0 && rsp_strobe |-> $past(start, 62))
      else $error("result without request");
endmodule

bind vec3_normalize_unit v3n_checker u_v3n_checker (
   .clock, .reset, .start, .busy, .rsp_strobe,
   .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_degenerate
);
